/* design/sensor_frame_crc4_packer_macros.svh */
// assertion macros shared by the sensor frame packer checkers
`ifndef SENSOR_FRAME_CRC4_PACKER_MACROS_SVH
`define SENSOR_FRAME_CRC4_PACKER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SFCP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfcp assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SFCP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfcp assertion failed");

`endif

/* design/sfcp_pkg.sv */
// package with widths, frame constants and crc-4 helpers for the sensor frame packer
`default_nettype none

package sfcp_pkg;

   localparam int SENSOR_ID_W   = 8;
   localparam int CHANNEL_W     = 2;
   localparam int TEMP_IN_W     = 11;
   localparam int HUMIDITY_W    = 7;
   localparam int FRAME_W       = 40;

   localparam int CRC_W         = 4;
   localparam int CRC_MSG_W     = 32;
   localparam logic [CRC_W-1:0] CRC_POLY = 4'h3;

   // temperature code: trunc((18*t + 12200) / 10)
   localparam int TEMP_NUM_W    = 16;
   localparam int TEMP_MAG_W    = 15;
   localparam int TEMP_CODE_W   = 12;
   localparam logic signed [TEMP_NUM_W-1:0] TEMP_OFFSET = 16'sd12200;
   // x / 10 == (x * 0xCCCD) >> 19 for every x below 81920
   localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
   localparam int DIV10_SHIFT   = 19;

   // humidity digits: h / 10 == (h * 205) >> 11 for every 7-bit h
   localparam int DIGIT_W       = 4;
   localparam logic [7:0] HUM_RECIP = 8'd205;
   localparam int HUM_SHIFT     = 11;
   localparam logic [HUMIDITY_W-1:0] HUM_BASE = 7'd10;

   typedef struct packed {
      logic [SENSOR_ID_W-1:0]       sensor_id;
      logic [CHANNEL_W-1:0]         channel_sel;
      logic                         battery_good;
      logic signed [TEMP_IN_W-1:0]  temp_tenths_c;
      logic [HUMIDITY_W-1:0]        humidity_pct;
   } reading_type;

   // bitwise crc-4, msb first, init zero
   function automatic logic [CRC_W-1:0] crc4_word(input logic [CRC_MSG_W-1:0] msg);
      logic [CRC_W-1:0] crc;
      logic             fb;
      crc = '0;
      for (int i = CRC_MSG_W - 1; i >= 0; i--) begin
         fb  = crc[CRC_W-1] ^ msg[i];
         crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return crc;
   endfunction

   // the crc is linear with zero init: each crc bit is the parity of a masked message
   function automatic logic [CRC_W-1:0][CRC_MSG_W-1:0] crc4_masks();
      logic [CRC_W-1:0][CRC_MSG_W-1:0] m;
      logic [CRC_W-1:0]                c;
      m = '0;
      for (int j = 0; j < CRC_MSG_W; j++) begin
         c = crc4_word(CRC_MSG_W'(1) << j);
         for (int i = 0; i < CRC_W; i++) begin
            m[i][j] = c[i];
         end
      end
      return m;
   endfunction

   localparam logic [CRC_W-1:0][CRC_MSG_W-1:0] CRC_MASKS = crc4_masks();

endpackage

`default_nettype wire

/* design/sfcp_req_if.sv */
// valid/ready channel carrying one sensor reading
`default_nettype none

interface sfcp_req_if
   import sfcp_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic [SENSOR_ID_W-1:0]       sensor_id;
   logic [CHANNEL_W-1:0]         channel_sel;
   logic                         battery_good;
   logic signed [TEMP_IN_W-1:0]  temp_tenths_c;
   logic [HUMIDITY_W-1:0]        humidity_pct;

   modport source (
      output valid, sensor_id, channel_sel, battery_good, temp_tenths_c, humidity_pct,
      input  ready
   );

   modport sink (
      input  valid, sensor_id, channel_sel, battery_good, temp_tenths_c, humidity_pct,
      output ready
   );
endinterface

`default_nettype wire

/* design/sfcp_rsp_if.sv */
// valid/ready channel carrying one packed 40-bit radio frame
`default_nettype none

interface sfcp_rsp_if
   import sfcp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame_bits;

   modport source (
      output valid, frame_bits,
      input  ready
   );

   modport sink (
      input  valid, frame_bits,
      output ready
   );
endinterface

`default_nettype wire

/* design/sensor_frame_crc4_packer.sv */
// top level of the sensor frame packer: reading in, crc-4 protected 40-bit frame out
`default_nettype none

// one reading in, one 40-bit frame out. a reading is taken on every transfer on
// req_ch and lands in an input register; the frame is built from that register in
// one pass (fahrenheit conversion through a constant reciprocal multiply, bcd
// humidity split, crc-4 as a parity tree per crc bit) and captured in an output
// register that drives rsp_ch. the block takes one reading per cycle as long as rsp_ch
// does not stall, and each frame passes through the two register stages in order.
// when rsp_ch stalls, both stages fill and req_ch.ready drops; a stage frees as
// soon as the one ahead of it moves, so no bubble is lost. no state is kept
// between readings and reset only clears the stage valid flags.
module sensor_frame_crc4_packer
   import sfcp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sfcp_req_if.sink   req_ch,
   sfcp_rsp_if.source rsp_ch
);

   // input stage
   reading_type s1_ff, s1_in;
   logic        s1_valid_ff, s1_valid_in;

   // output stage
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               s2_valid_ff, s2_valid_in;

   logic s1_load;
   logic s2_load;

   // frame build signals
   logic signed [TEMP_NUM_W-1:0]  t_ext;
   logic signed [TEMP_NUM_W-1:0]  t_num;
   logic                          t_neg;
   logic [TEMP_NUM_W-1:0]         t_abs;
   logic [TEMP_MAG_W-1:0]         t_mag;
   logic [TEMP_MAG_W+15:0]        t_prod;
   logic [TEMP_CODE_W-1:0]        t_qmag;
   logic [TEMP_CODE_W-1:0]        temp_code;

   logic [HUMIDITY_W+7:0]         h_prod;
   logic [DIGIT_W-1:0]            rh_tens;
   logic [HUMIDITY_W-1:0]         hum_rem;
   logic [DIGIT_W-1:0]            rh_units;

   logic                          low_batt;
   logic [CRC_MSG_W-1:0]          crc_msg;
   logic [CRC_W-1:0]              crc_raw;

   // handshake: the output stage frees when empty or when its frame is taken,
   // the input stage frees when empty or when it moves on
   assign s2_load      = !s2_valid_ff || rsp_ch.ready;
   assign s1_load      = !s1_valid_ff || s2_load;
   assign req_ch.ready = s1_load;

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in           = req_ch.valid;
         s1_in.sensor_id       = req_ch.sensor_id;
         s1_in.channel_sel     = req_ch.channel_sel;
         s1_in.battery_good    = req_ch.battery_good;
         s1_in.temp_tenths_c   = req_ch.temp_tenths_c;
         s1_in.humidity_pct    = req_ch.humidity_pct;
      end
   end

   // temperature: 18*t + 12200 as shift-add, then truncate toward zero by /10
   assign t_ext  = TEMP_NUM_W'(s1_ff.temp_tenths_c);
   assign t_num  = (t_ext <<< 4) + (t_ext <<< 1) + TEMP_OFFSET;
   assign t_neg  = t_num[TEMP_NUM_W-1];
   assign t_abs  = t_neg ? TEMP_NUM_W'(-t_num) : TEMP_NUM_W'(t_num);
   assign t_mag  = t_abs[TEMP_MAG_W-1:0];
   assign t_prod = t_mag * DIV10_RECIP;
   assign t_qmag = t_prod[DIV10_SHIFT +: TEMP_CODE_W];
   // negative quotients go out as their low 12 bits in two's complement
   assign temp_code = t_neg ? TEMP_CODE_W'(~t_qmag + 1'b1) : t_qmag;

   // humidity as two digits, the tens digit may exceed nine above 99 percent
   assign h_prod   = s1_ff.humidity_pct * HUM_RECIP;
   assign rh_tens  = h_prod[HUM_SHIFT +: DIGIT_W];
   assign hum_rem  = s1_ff.humidity_pct - HUMIDITY_W'(HUMIDITY_W'(rh_tens) * HUM_BASE);
   assign rh_units = hum_rem[DIGIT_W-1:0];

   assign low_batt = !s1_ff.battery_good;

   // crc message, taken from the frame with its crc nibble still zero:
   // id, then {frame[3:0], frame[27:24]}, then frame[23:16], then frame[15:8]
   assign crc_msg = {s1_ff.sensor_id,
                     2'b00, s1_ff.channel_sel, 1'b0, low_batt, 2'b00,
                     temp_code[TEMP_CODE_W-1:4],
                     temp_code[3:0], rh_tens};

   always_comb begin
      for (int i = 0; i < CRC_W; i++) begin
         crc_raw[i] = ^(crc_msg & CRC_MASKS[i]);
      end
   end

   always_comb begin
      frame_in    = frame_ff;
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
         frame_in    = {s1_ff.sensor_id,
                        crc_raw ^ rh_units,
                        1'b0, low_batt, 2'b00,
                        temp_code,
                        rh_tens, rh_units,
                        2'b00, s1_ff.channel_sel};
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      frame_ff <= frame_in;
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign rsp_ch.valid      = s2_valid_ff;
   assign rsp_ch.frame_bits = frame_ff;

endmodule

`default_nettype wire

/* design/sfcp_checker.sv */
// port-level checker for the sensor frame packer and its bind
`default_nettype none

`include "sensor_frame_crc4_packer_macros.svh"

module sfcp_checker
   import sfcp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [FRAME_W-1:0] frame_bits
);

   // a stalled frame stays offered
   `SFCP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled frame keeps its bits
   `SFCP_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(frame_bits))

   // input back-pressure only when the output is full and stalled
   `SFCP_ASSERT_IMP(a_ready_low, !req_ready, rsp_valid && !rsp_ready)

   // a taken reading reaches the output once the output side moves
   `SFCP_ASSERT_NXT(a_latency, (req_valid && req_ready) ##1 rsp_ready, rsp_valid)

endmodule

bind sensor_frame_crc4_packer sfcp_checker u_sfcp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .frame_bits (rsp_ch.frame_bits)
);

`default_nettype wire

/* verif/sensor_frame_crc4_packer_tb.sv */
// self-checking testbench for the sensor frame packer: readings in, crc-4 frames checked
`timescale 1ns / 100ps

module sensor_frame_crc4_packer_tb;
   import sfcp_pkg::*;

   // run shape
   localparam int RANDOM_READINGS  = 1800;
   localparam int LONG_HOLD_AT     = 900;   // frames seen before the long output stall
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 16;    // two register stages, plenty of margin
   localparam int IDLE_LIMIT       = 4000;  // cycles with no transfer on either side

   // one pending reading; hold_for_drain makes the sender wait for an empty pipe first
   typedef struct {
      reading_type rd;
      bit          hold_for_drain;
   } reading_slot_type;

   logic clock = 1'b0;
   logic reset;

   sfcp_req_if req_bus ();
   sfcp_rsp_if rsp_bus ();

   sensor_frame_crc4_packer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   reading_slot_type   reading_queue[$];     // stimulus not yet offered
   logic [FRAME_W-1:0] frame_expect_q[$];    // frames owed by the block, oldest first

   int mismatch_count;
   int readings_sent;
   int total_readings;
   int frames_checked;
   int cold_readings;      // temperature low enough to give a negative code
   int damp_readings;      // humidity above one hundred

   // ---------------------------------------------------------------
   // frame predictor
   // ---------------------------------------------------------------

   // one byte through crc-4 (x^4+x+1), msb first, remainder carried in the top nibble
   function automatic logic [CRC_W-1:0] crc4_step_byte(input logic [CRC_W-1:0] rem,
                                                       input logic [7:0] data);
      logic [7:0] acc;
      acc = {rem, 4'b0000} ^ data;
      for (int b = 0; b < 8; b++) begin
         if (acc[7])
            acc = {acc[6:0], 1'b0} ^ {CRC_POLY, 4'b0000};
         else
            acc = {acc[6:0], 1'b0};
      end
      return acc[7:4];
   endfunction

   function automatic logic [FRAME_W-1:0] build_frame(input reading_type rd);
      int                 temp_num;
      int                 temp_quot;
      logic [3:0]         tens_digit;
      logic [3:0]         units_digit;
      logic [CRC_W-1:0]   crc;
      logic [FRAME_W-1:0] frame;
      // fahrenheit tenths plus 900; integer division truncates toward zero
      temp_num    = 18 * int'(rd.temp_tenths_c) + 12200;
      temp_quot   = temp_num / 10;
      tens_digit  = 4'(rd.humidity_pct / 10);
      units_digit = 4'(rd.humidity_pct % 10);

      frame          = '0;
      frame[39:32]   = rd.sensor_id;
      frame[26]      = ~rd.battery_good;
      frame[23:12]   = temp_quot[11:0];
      frame[11:8]    = tens_digit;
      frame[7:4]     = units_digit;
      frame[1:0]     = rd.channel_sel;

      // crc runs over the frame with its nibble still zero, bytes rearranged
      crc = '0;
      crc = crc4_step_byte(crc, frame[39:32]);
      crc = crc4_step_byte(crc, {frame[3:0], frame[27:24]});
      crc = crc4_step_byte(crc, frame[23:16]);
      crc = crc4_step_byte(crc, frame[15:8]);
      frame[31:28] = crc ^ units_digit;
      return frame;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic add_reading(input int id, input int chan, input int batt_ok,
                              input int temp, input int hum, input bit hold);
      reading_slot_type slot;
      slot.rd.sensor_id     = SENSOR_ID_W'(id);
      slot.rd.channel_sel   = CHANNEL_W'(chan);
      slot.rd.battery_good  = 1'(batt_ok);
      slot.rd.temp_tenths_c = TEMP_IN_W'(temp);
      slot.rd.humidity_pct  = HUMIDITY_W'(hum);
      slot.hold_for_drain   = hold;
      if (slot.rd.temp_tenths_c < -678)
         cold_readings++;
      if (slot.rd.humidity_pct > 100)
         damp_readings++;
      reading_queue.push_back(slot);
   endtask

   // ---------------------------------------------------------------
   // driver: bursts of random length with random gaps in between
   // ---------------------------------------------------------------
   int               burst_left;
   int               gap_left;
   bit               offer_now;
   reading_slot_type next_slot;
   reading_type      taken;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left     = $urandom_range(1, 24);
         gap_left       = 0;
      end else begin
         // transfer on the input side: predict its frame right away
         if (req_bus.valid && req_bus.ready) begin
            taken.sensor_id     = req_bus.sensor_id;
            taken.channel_sel   = req_bus.channel_sel;
            taken.battery_good  = req_bus.battery_good;
            taken.temp_tenths_c = req_bus.temp_tenths_c;
            taken.humidity_pct  = req_bus.humidity_pct;
            frame_expect_q.push_back(build_frame(taken));
            readings_sent++;
         end
         // the bus is free for a new reading when idle or just transferred
         if (!req_bus.valid || req_bus.ready) begin
            offer_now = 1'b0;
            if (gap_left > 0)
               gap_left--;
            else if (reading_queue.size() > 0 &&
                     !(reading_queue[0].hold_for_drain && frame_expect_q.size() != 0))
               offer_now = 1'b1;

            if (offer_now) begin
               next_slot = reading_queue.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.sensor_id     <= next_slot.rd.sensor_id;
               req_bus.channel_sel   <= next_slot.rd.channel_sel;
               req_bus.battery_good  <= next_slot.rd.battery_good;
               req_bus.temp_tenths_c <= next_slot.rd.temp_tenths_c;
               req_bus.humidity_pct  <= next_slot.rd.humidity_pct;
               burst_left--;
               if (burst_left <= 0) begin
                  // a quarter of the bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                  burst_left = $urandom_range(1, 24);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: short random stalls, quiet phases, and one long hold-off
   // ---------------------------------------------------------------
   int stall_left;
   int phase_left;
   bit quiet_phase;
   int long_hold_left;
   bit long_hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left     = 0;
         phase_left     = 0;
         quiet_phase    = 1'b0;
         long_hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         // one long hold-off so both stages fill and the input backs up
         if (!long_hold_done && frames_checked >= LONG_HOLD_AT) begin
            long_hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               quiet_phase = ($urandom_range(0, 3) == 0);
               phase_left  = $urandom_range(16, 160);
            end else begin
               phase_left--;
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
               stall_left = $urandom_range(0, 6);
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: every frame transfer against the oldest prediction
   // ---------------------------------------------------------------
   logic [FRAME_W-1:0] want_frame;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         frames_checked++;
         if (frame_expect_q.size() == 0) begin
            report_mismatch($sformatf("frame %h with no reading outstanding",
                                      rsp_bus.frame_bits));
         end else begin
            want_frame = frame_expect_q.pop_front();
            if (rsp_bus.frame_bits !== want_frame)
               report_mismatch($sformatf("frame_bits got %h want %h", rsp_bus.frame_bits,
                                         want_frame));
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long without a transfer anywhere ends the run
   // ---------------------------------------------------------------
   int idle_cycles;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int  temp;
      int  hum;
      bit  hold;

      // known values on every input before the first edge
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.sensor_id     = '0;
      req_bus.channel_sel   = '0;
      req_bus.battery_good  = 1'b0;
      req_bus.temp_tenths_c = '0;
      req_bus.humidity_pct  = '0;
      rsp_bus.ready         = 1'b0;
      mismatch_count        = 0;
      readings_sent         = 0;
      total_readings        = 0;
      frames_checked        = 0;
      cold_readings         = 0;
      damp_readings         = 0;

      // directed corners: field extremes, both battery states, every channel,
      // the truncation boundary near -677 and humidity past one hundred
      add_reading(8'h00, 0, 1,     0,   0, 1'b0);
      add_reading(8'hFF, 3, 0,   850, 100, 1'b0);
      add_reading(8'hA5, 1, 1,  -400,  99, 1'b0);
      add_reading(8'h5A, 2, 0, -1024, 127, 1'b0);
      add_reading(8'h01, 0, 0,  1023,  10, 1'b0);
      add_reading(8'h80, 1, 1,    -1,   9, 1'b0);
      add_reading(8'h7F, 2, 1,     1, 101, 1'b0);
      add_reading(8'h3C, 3, 0,   851, 119, 1'b0);
      add_reading(8'hC3, 0, 1,  -401, 120, 1'b0);
      add_reading(8'h10, 1, 0,  -677,  55, 1'b0);
      add_reading(8'h20, 2, 1,  -678,  50, 1'b0);
      add_reading(8'h40, 3, 0,  -679,   1, 1'b0);
      add_reading(8'h08, 0, 1,  -684,  90, 1'b0);
      add_reading(8'hF0, 1, 0,    -5, 109, 1'b0);
      add_reading(8'h0F, 2, 1,     5,  11, 1'b0);
      add_reading(8'h55, 3, 1,  -200, 110, 1'b0);
      add_reading(8'hAA, 0, 0,   400,  19, 1'b0);
      add_reading(8'hFE, 1, 1, -1023,  64, 1'b0);

      // random readings: mostly within the sensor range, some anywhere in the field
      for (int i = 0; i < RANDOM_READINGS; i++) begin
         temp = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2047) - 1024
                                            : $urandom_range(0, 1250) - 400;
         hum  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, 100);
         // sender waits for an empty pipe before these two
         hold = (i == 0) || (i == 1300);
         add_reading($urandom_range(0, 255), $urandom_range(0, 3), $urandom_range(0, 1),
                     temp, hum, hold);
      end
      total_readings = reading_queue.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every reading transferred and every predicted frame back
      do
         @(posedge clock);
      while (readings_sent != total_readings || frame_expect_q.size() != 0);
      // stray frames after the last one would show up in this window
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (frame_expect_q.size() != 0)
         report_mismatch($sformatf("%0d frames never arrived", frame_expect_q.size()));

      $display("run covered %0d readings and %0d frames, incl. %0d with negative temp codes",
               readings_sent, frames_checked, cold_readings);
      $display("and %0d with humidity above 100, a long output hold-off and two drain pauses",
               damp_readings);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
